// ===== sv/prq_pkg.sv =====
// shared types, constants and codes of the priority ready queue
package prq_pkg;

   // queue storage
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W       = IDX_W + 1;

   // command queue between front and back
   localparam int FIFO_DEPTH  = 2;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   // field widths
   localparam int ID_W        = 8;
   localparam int PRIO_W      = 6;
   localparam int STATUS_W    = 3;
   localparam int OCC_W       = 5;

   // request command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED     = 3'd0,
      ST_FULL         = 3'd1,
      ST_POPPED       = 3'd2,
      ST_EMPTY        = 3'd3,
      ST_IDLE_IGNORED = 3'd4
   } status_type;

   // classified operation kinds
   typedef enum logic [1:0] {
      OP_INSERT,
      OP_POP,
      OP_IDLE_INSERT
   } op_kind_type;

   // operation passed from front to back
   typedef struct packed {
      op_kind_type         kind;
      logic [ID_W-1:0]     thread_id;
      logic [PRIO_W-1:0]   prio;
   } op_type;

   // one stored queue entry
   typedef struct packed {
      logic [ID_W-1:0]     thread_id;
      logic [PRIO_W-1:0]   prio;
   } entry_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_POP_RD,
      BK_INS_CMP,
      BK_INS_PUT
   } back_state_type;

endpackage

// ===== sv/priority_ready_queue.sv =====
// top level of the priority ready queue
//
//   channel  | ports                                                    | flow
//   ---------+----------------------------------------------------------+-------------
//   request  | req_valid req_stall req_cmd req_thread_id req_priority_req | in, stall
//   response | rsp_valid rsp_stall rsp_status rsp_next_id               | out, stall
//            | rsp_next_priority rsp_occupancy                          |
//   config   | csr_valid csr_ready csr_idle_thread_id                   | in, ready
//
// A pop on a non-empty queue reads the front entry in BK_POP_RD before its result is
// loaded; an empty pop, and an insert into an empty queue or when dropped or ignored,
// load their result from BK_IDLE. Other inserts scan, moving each entry behind their place
// back one slot, one entry per cycle through the single read port of the queue memory.
// Reset is synchronous, active high, and empties the queue with no clearing pass.
// A two-entry command queue lets requests be taken while a result waits on rsp_stall.
module priority_ready_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [prq_pkg::ID_W-1:0]       req_thread_id,
   input  logic [prq_pkg::PRIO_W-1:0]     req_priority_req,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [prq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [prq_pkg::ID_W-1:0]       rsp_next_id,
   output logic [prq_pkg::PRIO_W-1:0]     rsp_next_priority,
   output logic [prq_pkg::OCC_W-1:0]      rsp_occupancy,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [prq_pkg::ID_W-1:0]       csr_idle_thread_id
);

   logic             push_valid;
   prq_pkg::op_type  push_op;
   logic             queue_full;
   logic             op_valid;
   prq_pkg::op_type  op_head;
   logic             op_take;

   // intake and classification
   prq_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_thread_id      (req_thread_id),
      .req_priority_req   (req_priority_req),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_idle_thread_id (csr_idle_thread_id),
      .push_valid         (push_valid),
      .push_op            (push_op),
      .queue_full         (queue_full)
   );

   // command queue
   prq_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .full       (queue_full),
      .pop_valid  (op_valid),
      .pop_take   (op_take),
      .pop_op     (op_head)
   );

   // queue engine
   prq_back u_back (
      .clock             (clock),
      .reset             (reset),
      .op_valid          (op_valid),
      .op_in             (op_head),
      .op_take           (op_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_next_id       (rsp_next_id),
      .rsp_next_priority (rsp_next_priority),
      .rsp_occupancy     (rsp_occupancy)
   );

   // a dropped insert only happens on a full queue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == prq_pkg::ST_FULL |->
         rsp_occupancy == prq_pkg::OCC_W'(prq_pkg::QUEUE_DEPTH))
      else $error("full status with queue not full");

   // an empty pop reports an empty queue and no priority
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == prq_pkg::ST_EMPTY |->
         rsp_occupancy == '0 && rsp_next_priority == '0)
      else $error("empty pop with entries or priority");

   // insert outcomes carry no id or priority
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == prq_pkg::ST_INSERTED || rsp_status == prq_pkg::ST_FULL ||
                    rsp_status == prq_pkg::ST_IDLE_IGNORED) |->
         rsp_next_id == '0 && rsp_next_priority == '0)
      else $error("insert result with nonzero id or priority");

   // the back end takes an operation only when the command queue holds one
   assert property (@(posedge clock) disable iff (reset)
      op_take |-> op_valid)
      else $error("operation taken from empty command queue");

endmodule

// ===== sv/prq_front.sv =====
// front end: request intake, idle id register and command classification
module prq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [prq_pkg::ID_W-1:0]      req_thread_id,
   input  logic [prq_pkg::PRIO_W-1:0]    req_priority_req,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [prq_pkg::ID_W-1:0]      csr_idle_thread_id,
   output logic                          push_valid,
   output prq_pkg::op_type               push_op,
   input  logic                          queue_full
);

   logic [prq_pkg::ID_W-1:0] idle_id_ff;
   logic [prq_pkg::ID_W-1:0] idle_id_in;

   // idle id register
   assign csr_ready  = 1'b1;
   assign idle_id_in = (csr_valid && csr_ready) ? csr_idle_thread_id : idle_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_id_ff <= '0;
      end else begin
         idle_id_ff <= idle_id_in;
      end
   end

   // intake stalls only when the command queue is full
   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

   // classify: a pop carries the idle id for the empty case
   always_comb begin
      push_op.prio = req_priority_req;
      if (req_cmd == prq_pkg::CMD_POP) begin
         push_op.kind      = prq_pkg::OP_POP;
         push_op.thread_id = idle_id_ff;
      end else if (req_thread_id == idle_id_ff) begin
         push_op.kind      = prq_pkg::OP_IDLE_INSERT;
         push_op.thread_id = req_thread_id;
      end else begin
         push_op.kind      = prq_pkg::OP_INSERT;
         push_op.thread_id = req_thread_id;
      end
   end

endmodule

// ===== sv/prq_fifo.sv =====
// short command queue decoupling front end and back end
module prq_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  prq_pkg::op_type   push_op,
   output logic              full,
   output logic              pop_valid,
   input  logic              pop_take,
   output prq_pkg::op_type   pop_op
);

   prq_pkg::op_type                     slot_ff [prq_pkg::FIFO_DEPTH];
   logic [prq_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [prq_pkg::FIFO_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [prq_pkg::FIFO_CNT_W-1:0]      count_ff, count_in;
   logic                                do_push, do_pop;

   assign full      = (count_ff == prq_pkg::FIFO_CNT_W'(prq_pkg::FIFO_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_op    = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_take && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == prq_pkg::FIFO_PTR_W'(prq_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == prq_pkg::FIFO_PTR_W'(prq_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + prq_pkg::FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - prq_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== sv/prq_back.sv =====
// back end: ring-buffer queue memory, insertion scan and result register
module prq_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           op_valid,
   input  prq_pkg::op_type                op_in,
   output logic                           op_take,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [prq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [prq_pkg::ID_W-1:0]       rsp_next_id,
   output logic [prq_pkg::PRIO_W-1:0]     rsp_next_priority,
   output logic [prq_pkg::OCC_W-1:0]      rsp_occupancy
);

   // logical position to ring address
   function automatic logic [prq_pkg::IDX_W-1:0] ring_addr(
      input logic [prq_pkg::IDX_W-1:0] head,
      input logic [prq_pkg::CNT_W-1:0] pos
   );
      logic [prq_pkg::SUM_W-1:0] sum;
      sum = prq_pkg::SUM_W'(head) + prq_pkg::SUM_W'(pos);
      if (sum >= prq_pkg::SUM_W'(prq_pkg::QUEUE_DEPTH)) begin
         sum = sum - prq_pkg::SUM_W'(prq_pkg::QUEUE_DEPTH);
      end
      return sum[prq_pkg::IDX_W-1:0];
   endfunction

   prq_pkg::entry_type                mem [prq_pkg::QUEUE_DEPTH];
   prq_pkg::entry_type                rd_ff;

   prq_pkg::back_state_type           state_ff, state_in;
   logic [prq_pkg::IDX_W-1:0]         head_ff, head_in;
   logic [prq_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [prq_pkg::CNT_W-1:0]         idx_ff, idx_in;
   prq_pkg::op_type                   op_ff, op_in_reg;

   logic                              rsp_valid_ff, rsp_valid_in;
   prq_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [prq_pkg::ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic [prq_pkg::PRIO_W-1:0]        rsp_prio_ff, rsp_prio_in;
   logic [prq_pkg::OCC_W-1:0]         rsp_occ_ff, rsp_occ_in;
   logic                              rsp_load;

   logic                              mem_we;
   logic [prq_pkg::IDX_W-1:0]         mem_waddr;
   prq_pkg::entry_type                mem_wdata;
   logic [prq_pkg::IDX_W-1:0]         mem_raddr;

   logic                              is_empty, is_full, is_last, shift_on;
   logic [prq_pkg::CNT_W-1:0]         idx_minus1;

   // shared conditions
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH));
   assign is_last    = (idx_ff == prq_pkg::CNT_W'(1));
   assign shift_on   = (op_ff.prio > rd_ff.prio);
   assign idx_minus1 = idx_ff - prq_pkg::CNT_W'(1);
   assign op_take    = (state_ff == prq_pkg::BK_IDLE) && op_valid &&
                       (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prq_pkg::BK_IDLE: begin
            if (op_take) begin
               if (op_in.kind == prq_pkg::OP_POP && !is_empty) begin
                  state_in = prq_pkg::BK_POP_RD;
               end else if (op_in.kind == prq_pkg::OP_INSERT && !is_empty && !is_full) begin
                  state_in = prq_pkg::BK_INS_CMP;
               end
            end
         end
         prq_pkg::BK_POP_RD: begin
            state_in = prq_pkg::BK_IDLE;
         end
         prq_pkg::BK_INS_CMP: begin
            if (!shift_on) begin
               state_in = prq_pkg::BK_IDLE;
            end else if (is_last) begin
               state_in = prq_pkg::BK_INS_PUT;
            end
         end
         prq_pkg::BK_INS_PUT: begin
            state_in = prq_pkg::BK_IDLE;
         end
         default: begin
            state_in = prq_pkg::BK_IDLE;
         end
      endcase
   end

   // datapath control per state
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      op_in_reg     = op_ff;
      mem_we        = 1'b0;
      mem_waddr     = head_ff;
      mem_wdata     = rd_ff;
      mem_raddr     = head_ff;
      rsp_load      = 1'b0;
      rsp_status_in = prq_pkg::ST_INSERTED;
      rsp_id_in     = '0;
      rsp_prio_in   = '0;
      case (state_ff)
         prq_pkg::BK_IDLE: begin
            if (op_take) begin
               op_in_reg = op_in;
               case (op_in.kind)
                  prq_pkg::OP_POP: begin
                     if (is_empty) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = prq_pkg::ST_EMPTY;
                        rsp_id_in     = op_in.thread_id;
                     end
                  end
                  prq_pkg::OP_INSERT: begin
                     if (is_full) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = prq_pkg::ST_FULL;
                     end else if (is_empty) begin
                        mem_we         = 1'b1;
                        mem_wdata.thread_id = op_in.thread_id;
                        mem_wdata.prio = op_in.prio;
                        count_in       = count_ff + prq_pkg::CNT_W'(1);
                        rsp_load       = 1'b1;
                     end else begin
                        mem_raddr = ring_addr(head_ff, count_ff - prq_pkg::CNT_W'(1));
                        idx_in    = count_ff;
                     end
                  end
                  default: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = prq_pkg::ST_IDLE_IGNORED;
                  end
               endcase
            end
         end
         prq_pkg::BK_POP_RD: begin
            // front entry leaves: advance head
            head_in       = (head_ff == prq_pkg::IDX_W'(prq_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : head_ff + prq_pkg::IDX_W'(1);
            count_in      = count_ff - prq_pkg::CNT_W'(1);
            rsp_load      = 1'b1;
            rsp_status_in = prq_pkg::ST_POPPED;
            rsp_id_in     = rd_ff.thread_id;
            rsp_prio_in   = rd_ff.prio;
         end
         prq_pkg::BK_INS_CMP: begin
            // rd_ff holds entry idx-1; move it back or drop the new one in
            mem_we    = 1'b1;
            mem_waddr = ring_addr(head_ff, idx_ff);
            if (shift_on) begin
               mem_wdata = rd_ff;
               idx_in    = idx_minus1;
               mem_raddr = ring_addr(head_ff, idx_minus1 - prq_pkg::CNT_W'(1));
            end else begin
               mem_wdata.thread_id = op_ff.thread_id;
               mem_wdata.prio      = op_ff.prio;
               count_in  = count_ff + prq_pkg::CNT_W'(1);
               rsp_load  = 1'b1;
            end
         end
         prq_pkg::BK_INS_PUT: begin
            mem_we              = 1'b1;
            mem_waddr           = ring_addr(head_ff, idx_ff);
            mem_wdata.thread_id = op_ff.thread_id;
            mem_wdata.prio      = op_ff.prio;
            count_in            = count_ff + prq_pkg::CNT_W'(1);
            rsp_load            = 1'b1;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_occ_in   = prq_pkg::OCC_W'(count_in);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prq_pkg::BK_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operation and result payload
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      op_ff  <= op_in_reg;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   // queue memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_next_id       = rsp_id_ff;
   assign rsp_next_priority = rsp_prio_ff;
   assign rsp_occupancy     = rsp_occ_ff;

endmodule

// ===== test/priority_ready_queue_check.sv =====
// scoreboard for the priority ready queue: watches all channels, predicts and compares results
module priority_ready_queue_check (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [prq_pkg::ID_W-1:0]     req_thread_id,
   input  logic [prq_pkg::PRIO_W-1:0]   req_priority_req,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [prq_pkg::STATUS_W-1:0] rsp_status,
   input  logic [prq_pkg::ID_W-1:0]     rsp_next_id,
   input  logic [prq_pkg::PRIO_W-1:0]   rsp_next_priority,
   input  logic [prq_pkg::OCC_W-1:0]    rsp_occupancy,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [prq_pkg::ID_W-1:0]     csr_idle_thread_id,
   output int                           rsp_count,
   output int                           fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // one scheduling outcome as it should appear on the response channel
   typedef struct packed {
      prq_pkg::status_type          status;
      logic [prq_pkg::ID_W-1:0]     thread_id;
      logic [prq_pkg::PRIO_W-1:0]   prio;
      logic [prq_pkg::OCC_W-1:0]    occupancy;
   } outcome_type;

   prq_pkg::entry_type       pending_threads[$];
   outcome_type              due_outcomes[$];
   outcome_type              oldest;
   logic [prq_pkg::ID_W-1:0] idle_id = '0;
   int                       mismatches = 0;
   int                       results_seen = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, wanted %0h", name, got, want));
      end
   endtask

   // schedule one request against the pending threads and queue the outcome it should give
   task automatic schedule_request(input logic cmd, input logic [prq_pkg::ID_W-1:0] tid,
                                   input logic [prq_pkg::PRIO_W-1:0] pr);
      outcome_type        o;
      prq_pkg::entry_type e;
      int                 slot;
      o = '{status: prq_pkg::ST_INSERTED, thread_id: '0, prio: '0, occupancy: '0};
      if (cmd == prq_pkg::CMD_POP) begin
         if (pending_threads.size() == 0) begin
            o.status    = prq_pkg::ST_EMPTY;
            o.thread_id = idle_id;
         end else begin
            e           = pending_threads.pop_front();
            o.status    = prq_pkg::ST_POPPED;
            o.thread_id = e.thread_id;
            o.prio      = e.prio;
         end
      end else if (tid == idle_id) begin
         o.status = prq_pkg::ST_IDLE_IGNORED;
      end else if (pending_threads.size() >= prq_pkg::QUEUE_DEPTH) begin
         o.status = prq_pkg::ST_FULL;
      end else begin
         // goes in front of the first entry of strictly lower priority
         slot = pending_threads.size();
         for (int i = 0; i < pending_threads.size(); i++) begin
            if (pr > pending_threads[i].prio) begin
               slot = i;
               break;
            end
         end
         e.thread_id = tid;
         e.prio      = pr;
         pending_threads.insert(slot, e);
      end
      o.occupancy = prq_pkg::OCC_W'(pending_threads.size());
      due_outcomes.push_back(o);
   endtask

   // sample every transfer at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         pending_threads.delete();
         due_outcomes.delete();
         idle_id = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            idle_id = csr_idle_thread_id;
         end
         if (req_valid && !req_stall) begin
            schedule_request(req_cmd, req_thread_id, req_priority_req);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (due_outcomes.size() == 0) begin
               report_mismatch($sformatf("result status %0d with nothing outstanding",
                                         rsp_status));
            end else begin
               oldest = due_outcomes.pop_front();
               check_field("status", 8'(rsp_status), 8'(oldest.status));
               check_field("next_id", rsp_next_id, oldest.thread_id);
               check_field("next_priority", 8'(rsp_next_priority), 8'(oldest.prio));
               check_field("occupancy", 8'(rsp_occupancy), 8'(oldest.occupancy));
            end
         end
      end
      rsp_count  <= results_seen;
      fail_count <= mismatches + due_outcomes.size();
   end

endmodule

// ===== test/priority_ready_queue_test.sv =====
// stimulus and verdict for the priority ready queue, with clock, reset and idling control
module priority_ready_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_cmd;
   logic [prq_pkg::ID_W-1:0]     req_thread_id;
   logic [prq_pkg::PRIO_W-1:0]   req_priority_req;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [prq_pkg::STATUS_W-1:0] rsp_status;
   logic [prq_pkg::ID_W-1:0]     rsp_next_id;
   logic [prq_pkg::PRIO_W-1:0]   rsp_next_priority;
   logic [prq_pkg::OCC_W-1:0]    rsp_occupancy;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [prq_pkg::ID_W-1:0]     csr_idle_thread_id;

   int                           rsp_count;
   int                           fail_count;
   int                           sent_count;
   int                           idle_pct;
   int                           stall_pct;
   int                           hold_left;
   logic                         hold_go;
   logic [prq_pkg::ID_W-1:0]     cur_idle;
   int                           idle_table[4]  = '{0, 60, 0, 29};
   int                           stall_table[4] = '{0, 0, 60, 29};

   priority_ready_queue u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_thread_id      (req_thread_id),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_next_id        (rsp_next_id),
      .rsp_next_priority  (rsp_next_priority),
      .rsp_occupancy      (rsp_occupancy),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_idle_thread_id (csr_idle_thread_id)
   );

   priority_ready_queue_check u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_thread_id      (req_thread_id),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_next_id        (rsp_next_id),
      .rsp_next_priority  (rsp_next_priority),
      .rsp_occupancy      (rsp_occupancy),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_idle_thread_id (csr_idle_thread_id),
      .rsp_count          (rsp_count),
      .fail_count         (fail_count)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("priority_ready_queue verification failed");
      $finish;
   end

   // response back-pressure: random stalls, or a long hold-off when asked for
   initial begin
      rsp_stall <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_go && hold_left == 0) begin
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // offer one request, with random idle cycles ahead of it, and wait for its transfer
   task automatic send_request(input logic cmd, input logic [prq_pkg::ID_W-1:0] tid,
                               input logic [prq_pkg::PRIO_W-1:0] pr);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_thread_id    <= tid;
      req_priority_req <= pr;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (rsp_count < sent_count) begin
         @(posedge clock);
      end
   endtask

   task automatic write_idle_id(input logic [prq_pkg::ID_W-1:0] value);
      csr_valid          <= 1'b1;
      csr_idle_thread_id <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      cur_idle  = value;
   endtask

   // random traffic in bursts that lean toward filling, balancing or draining
   task automatic run_random(input int count);
      int                         ins_pct;
      int                         base;
      logic                       cmd;
      logic [prq_pkg::ID_W-1:0]   tid;
      logic [prq_pkg::PRIO_W-1:0] pr;
      ins_pct = 50;
      base    = 0;
      for (int n = 0; n < count; n++) begin
         if (n % 48 == 0) begin
            case ($urandom_range(0, 2))
               0: ins_pct = 85;
               1: ins_pct = 50;
               default: ins_pct = 20;
            endcase
            base = $urandom_range(0, 60);
         end
         cmd = ($urandom_range(0, 99) < ins_pct) ? prq_pkg::CMD_INSERT : prq_pkg::CMD_POP;
         tid = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < 6) begin
            tid = cur_idle;
         end
         // clustered priorities give plenty of ties
         case ($urandom_range(0, 3))
            0, 1: pr = 6'(base + $urandom_range(0, 3));
            2: pr = 6'($urandom_range(0, 63));
            default: pr = $urandom_range(0, 1) ? 6'd63 : 6'd0;
         endcase
         send_request(cmd, tid, pr);
      end
   endtask

   // main sequence
   initial begin
      logic [prq_pkg::ID_W-1:0] value;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_cmd            <= prq_pkg::CMD_INSERT;
      req_thread_id      <= '0;
      req_priority_req   <= '0;
      csr_valid          <= 1'b0;
      csr_idle_thread_id <= '0;
      hold_go            <= 1'b0;
      stall_pct          <= 0;
      idle_pct   = 0;
      sent_count = 0;
      cur_idle   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop and idle insert under the reset idle id
      send_request(prq_pkg::CMD_POP, 8'hA5, 6'h3F);
      send_request(prq_pkg::CMD_INSERT, 8'h00, 6'd5);
      // ordering, ties at both priority extremes
      send_request(prq_pkg::CMD_INSERT, 8'hFF, 6'd63);
      send_request(prq_pkg::CMD_INSERT, 8'h01, 6'd0);
      send_request(prq_pkg::CMD_INSERT, 8'h80, 6'd63);
      send_request(prq_pkg::CMD_INSERT, 8'h7E, 6'd32);
      send_request(prq_pkg::CMD_INSERT, 8'h55, 6'd0);
      send_request(prq_pkg::CMD_POP, 8'h00, 6'd0);
      // new idle id equal to an entry already queued
      wait_drained();
      write_idle_id(8'h80);
      send_request(prq_pkg::CMD_INSERT, 8'h80, 6'd10);
      // fill up, then a dropped insert and an idle insert on a full queue
      for (int i = 0; i < 12; i++) begin
         send_request(prq_pkg::CMD_INSERT, 8'(i * 21 + 5), 6'((i * 23) % 64));
      end
      send_request(prq_pkg::CMD_INSERT, 8'h33, 6'd20);
      send_request(prq_pkg::CMD_INSERT, 8'h80, 6'd0);

      // random phases, each after writing an idle id and picking an idling and stall mix
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         case (phase)
            0, 3: value = 8'hFF;
            1, 5: value = 8'h00;
            default: value = 8'($urandom_range(0, 255));
         endcase
         write_idle_id(value);
         idle_pct = idle_table[phase % 4];
         stall_pct <= stall_table[phase % 4];
         if (phase == 0 || phase == 5) begin
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         run_random(225);
      end

      // drain and settle
      wait_drained();
      stall_pct <= 0;
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("priority_ready_queue verification clean");
      end else begin
         $display("priority_ready_queue verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/prq_pkg.sv
sv/prq_front.sv
sv/prq_fifo.sv
sv/prq_back.sv
sv/priority_ready_queue.sv
test/priority_ready_queue_check.sv
test/priority_ready_queue_test.sv
